FILE: rtl/rgbmf_pkg.sv
// shared types, constants and the mod3 helper function of the rgb median/mean filter
package rgbmf_pkg;

   localparam int WINDOW_ROWS = 3;
   localparam int WIN_SIZE    = 9;
   localparam int PIX_W       = 8;

   // sum of nine pixels, less the centre, plus twice the median: at most 2550
   localparam int ACC_W       = 12;
   localparam int SLOT_W      = 4;

   localparam logic [1:0] LAST_ROW   = 2'(WINDOW_ROWS - 1);

   localparam logic [1:0] LOAD_NONE  = 2'd0;
   localparam logic [1:0] LOAD_SLOT1 = 2'd1;
   localparam logic [1:0] LOAD_SLOT2 = 2'd2;

   localparam logic [SLOT_W-1:0] CENTRE_LEFT  = 4'd3;
   localparam logic [SLOT_W-1:0] CENTRE_MID   = 4'd4;
   localparam logic [SLOT_W-1:0] CENTRE_RIGHT = 4'd5;

   localparam logic [3:0] MEDIAN_RANK = 4'd4;

   // x / 10 == (x * 6554) >> 16 for every x below 2560
   localparam int          RECIP_W     = 13;
   localparam int          RECIP_SHIFT = 16;
   localparam int          PROD_W      = ACC_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;

   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

   // x mod 3 for 8 bit x, via reciprocal multiply (x * 171) >> 9
   function automatic logic [1:0] mod3(input logic [7:0] x);
      logic [16:0] p;
      logic [7:0]  q;
      logic [9:0]  r;
      p = 17'(x) * 17'd171;
      q = p[16:9];
      r = 10'(x) - 10'(q) * 10'd3;
      return r[1:0];
   endfunction

endpackage

FILE: rtl/rgbmf_window.sv
// window store and row load control, with the snapshot register for the lanes
module rgbmf_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          load,
   input  logic [7:0]                    column,
   input  logic [7:0]                    red_in,
   input  logic [7:0]                    green_in,
   input  logic [7:0]                    blue_in,
   output logic                          fire,
   output rgbmf_pkg::win_type            snap_red_ff,
   output rgbmf_pkg::win_type            snap_green_ff,
   output rgbmf_pkg::win_type            snap_blue_ff,
   output logic [rgbmf_pkg::SLOT_W-1:0]  snap_centre_ff
);
   import rgbmf_pkg::*;

   win_type             red_ff, red_in_w;
   win_type             green_ff, green_in_w;
   win_type             blue_ff, blue_in_w;
   logic [1:0]          row_index_ff, row_index_in;
   logic [1:0]          load_pos_ff, load_pos_in;
   logic [7:0]          row_column_ff, row_column_in;
   logic [1:0]          row;
   logic [1:0]          slot;
   logic [SLOT_W-1:0]   idx;
   logic                done;
   logic [SLOT_W-1:0]   centre;

   always_comb begin
      row           = (row_index_ff >= LAST_ROW) ? LAST_ROW : row_index_ff;
      load_pos_in   = load_pos_ff;
      row_column_in = row_column_ff;
      row_index_in  = row_index_ff;
      done          = 1'b0;
      slot          = 2'd0;
      if (load_pos_ff == LOAD_SLOT1) begin
         slot        = 2'd1;
         load_pos_in = LOAD_SLOT2;
      end else if (load_pos_ff == LOAD_SLOT2) begin
         slot        = 2'd2;
         load_pos_in = LOAD_NONE;
         done        = 1'b1;
      end else if (column == 8'd0) begin
         slot          = 2'd0;
         load_pos_in   = LOAD_SLOT1;
         row_column_in = 8'd0;
      end else begin
         slot          = mod3(column - 8'd1);
         load_pos_in   = LOAD_NONE;
         row_column_in = column;
         done          = 1'b1;
      end
      idx = 4'({row, 1'b0}) + 4'(row) + 4'(slot);

      red_in_w   = red_ff;
      green_in_w = green_ff;
      blue_in_w  = blue_ff;
      if (accept) begin
         red_in_w[idx]   = red_in;
         green_in_w[idx] = green_in;
         blue_in_w[idx]  = blue_in;
      end
      if (accept && done) begin
         row_index_in = (row == LAST_ROW) ? 2'd0 : row + 2'd1;
      end
      fire = accept && done && (row == LAST_ROW);

      case (mod3(row_column_in))
         2'd0:    centre = CENTRE_MID;
         2'd1:    centre = CENTRE_RIGHT;
         default: centre = CENTRE_LEFT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff        <= '0;
         green_ff      <= '0;
         blue_ff       <= '0;
         row_index_ff  <= 2'd0;
         load_pos_ff   <= LOAD_NONE;
         row_column_ff <= 8'd0;
      end else if (accept) begin
         red_ff        <= red_in_w;
         green_ff      <= green_in_w;
         blue_ff       <= blue_in_w;
         row_index_ff  <= row_index_in;
         load_pos_ff   <= load_pos_in;
         row_column_ff <= row_column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_red_ff    <= red_in_w;
         snap_green_ff  <= green_in_w;
         snap_blue_ff   <= blue_in_w;
         snap_centre_ff <= centre;
      end
   end

endmodule

FILE: rtl/rgbmf_lane.sv
// one colour lane: rank-based median, window sum, combine and divide by ten
module rgbmf_lane (
   input  logic                          clock,
   input  rgbmf_pkg::win_type            win,
   input  logic [rgbmf_pkg::SLOT_W-1:0]  centre,
   input  rgbmf_pkg::adv_type            adv,
   output logic [rgbmf_pkg::PIX_W-1:0]   result_ff
);
   import rgbmf_pkg::*;

   // stage 2
   logic [WIN_SIZE-1:0] is_med_ff, is_med_in;
   win_type             win2_ff;
   logic [ACC_W-1:0]    sum_ff, sum_in;
   logic [PIX_W-1:0]    cval_ff;
   logic [3:0]          cnt;
   // stage 3
   logic [PIX_W-1:0]    med;
   logic [ACC_W-1:0]    comb_ff, comb_in;
   // stage 4
   logic [PROD_W-1:0]   prod;

   // rank with index tie-break: exactly one element has rank four
   always_comb begin
      cnt    = 4'd0;
      sum_in = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         cnt = 4'd0;
         for (int j = 0; j < WIN_SIZE; j++) begin
            if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
               cnt = cnt + 4'd1;
            end
         end
         is_med_in[i] = (cnt == MEDIAN_RANK);
         sum_in       = sum_in + ACC_W'(win[i]);
      end
   end

   always_comb begin
      med = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         med = med | (is_med_ff[i] ? win2_ff[i] : '0);
      end
      comb_in = sum_ff - ACC_W'(cval_ff) + ACC_W'({med, 1'b0});
      prod    = PROD_W'(comb_ff) * PROD_W'(RECIP_TEN);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         is_med_ff <= is_med_in;
         win2_ff   <= win;
         sum_ff    <= sum_in;
         cval_ff   <= win[centre];
      end
      if (adv.s3) begin
         comb_ff <= comb_in;
      end
      if (adv.s4) begin
         result_ff <= prod[RECIP_SHIFT +: PIX_W];
      end
   end

endmodule

FILE: rtl/rgb_median_mean_3x3_filter.sv
// top level of the rgb 3x3 median-weighted mean filter
//
//  channel  | ports           | payload (lowest bits first)
//  ---------+-----------------+------------------------------------------
//  request  | req_t*  (in)    | column, red_in, green_in, blue_in (8 each)
//  result   | rsp_t*  (out)   | red_out, green_out, blue_out (8 each)
//
// one request per clock when the result side keeps up; the request that completes the third row
// yields a result after passing the snapshot, rank+sum, combine and output registers
// pipeline: window/snapshot, rank+sum, median combine, divide-by-ten output
// register, each stage stalls only when the one after it is full
// reset (synchronous) clears the windows, row/load control and all valids
// req_tready drops only when all four stages hold results
module rgb_median_mean_3x3_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // column, red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red_out, green_out, blue_out
);
   import rgbmf_pkg::*;

   logic               accept;
   logic               fire;
   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   logic               v3_ff, v3_in;
   logic               v4_ff, v4_in;
   logic               ld1, ld2, ld3, ld4;
   adv_type            adv;
   win_type            snap_red, snap_green, snap_blue;
   logic [SLOT_W-1:0]  snap_centre;
   logic [PIX_W-1:0]   red_res, green_res, blue_res;

   // each stage loads when empty or when the next stage is loading
   always_comb begin
      ld4    = !v4_ff || rsp_tready;
      ld3    = !v3_ff || ld4;
      ld2    = !v2_ff || ld3;
      ld1    = !v1_ff || ld2;
      accept = req_tvalid && ld1;
      v1_in  = ld1 ? fire  : v1_ff;
      v2_in  = ld2 ? v1_ff : v2_ff;
      v3_in  = ld3 ? v2_ff : v3_ff;
      v4_in  = ld4 ? v3_ff : v4_ff;
      adv.s2 = ld2;
      adv.s3 = ld3;
      adv.s4 = ld4;
   end

   assign req_tready = ld1;
   assign rsp_tvalid = v4_ff;
   // merge the three lanes into one result word
   assign rsp_tdata  = {blue_res, green_res, red_res};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // window rows and centre pick; snapshot feeds the lanes
   rgbmf_window u_window (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .load           (ld1),
      .column         (req_tdata[7:0]),
      .red_in         (req_tdata[15:8]),
      .green_in       (req_tdata[23:16]),
      .blue_in        (req_tdata[31:24]),
      .fire           (fire),
      .snap_red_ff    (snap_red),
      .snap_green_ff  (snap_green),
      .snap_blue_ff   (snap_blue),
      .snap_centre_ff (snap_centre)
   );

   // one lane per colour, all stepping together
   rgbmf_lane u_lane_red (
      .clock     (clock),
      .win       (snap_red),
      .centre    (snap_centre),
      .adv       (adv),
      .result_ff (red_res)
   );

   rgbmf_lane u_lane_green (
      .clock     (clock),
      .win       (snap_green),
      .centre    (snap_centre),
      .adv       (adv),
      .result_ff (green_res)
   );

   rgbmf_lane u_lane_blue (
      .clock     (clock),
      .win       (snap_blue),
      .centre    (snap_centre),
      .adv       (adv),
      .result_ff (blue_res)
   );

`ifndef SYNTHESIS
   // a new snapshot only comes from an accepted request
   a_snap_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(v1_ff) |-> $past(req_tvalid && req_tready))
      else $error("snapshot valid without an accepted request");

   // the request side stalls only when every stage is full
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("request stalled with an empty stage");

   // a result appears only after the combine stage held one
   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v3_ff))
      else $error("result valid without a combine stage entry");
`endif

endmodule

FILE: tb/rgbmf_filter_checker.sv
`timescale 1ns / 1ps
// result checker for the rgb median/mean filter: tracks the window and compares every result
module rgbmf_filter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // column, red_in, green_in, blue_in
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // red_out, green_out, blue_out
   output int          error_total,
   output int          waiting_results
);
   import rgbmf_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_pixel_type;

   win_type          red_win;
   win_type          green_win;
   win_type          blue_win;
   logic [1:0]       row_now;
   logic [1:0]       load_pos;
   logic [7:0]       centre_col;
   rgb_pixel_type    filtered_q[$];

   // sum of the window less the centre plus twice the median, over ten
   function automatic logic [PIX_W-1:0] filter_value(input win_type w, input int centre);
      int sorted [WIN_SIZE];
      int total;
      int hold;
      int i;
      int j;
      total = 0;
      for (i = 0; i < WIN_SIZE; i++) begin
         sorted[i] = int'(w[i]);
         total += int'(w[i]);
      end
      for (i = 1; i < WIN_SIZE; i++) begin
         hold = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > hold) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = hold;
      end
      total = total - int'(w[centre]) + 2 * sorted[WIN_SIZE / 2];
      return PIX_W'(total / 10);
   endfunction

   function automatic void store_pixel(input int row, input int slot, input logic [31:0] word);
      int idx;
      idx = row * 3 + slot;
      red_win[idx]   = word[15:8];
      green_win[idx] = word[23:16];
      blue_win[idx]  = word[31:24];
   endfunction

   always @(posedge clock) begin : track
      int            row;
      int            centre;
      int            bad;
      logic          finished;
      rgb_pixel_type want;
      rgb_pixel_type got;
      if (reset) begin
         red_win    = '0;
         green_win  = '0;
         blue_win   = '0;
         row_now    = '0;
         load_pos   = LOAD_NONE;
         centre_col = '0;
         filtered_q.delete();
         error_total <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            row = (row_now > LAST_ROW) ? int'(LAST_ROW) : int'(row_now);
            finished = 1'b0;
            case (load_pos)
               LOAD_SLOT1: begin
                  store_pixel(row, 1, req_tdata);
                  load_pos = LOAD_SLOT2;
               end
               LOAD_SLOT2: begin
                  store_pixel(row, 2, req_tdata);
                  load_pos = LOAD_NONE;
                  finished = 1'b1;
               end
               default: begin
                  if (req_tdata[7:0] == 8'd0) begin
                     store_pixel(row, 0, req_tdata);
                     load_pos   = LOAD_SLOT1;
                     centre_col = '0;
                  end else begin
                     store_pixel(row, (int'(req_tdata[7:0]) - 1) % 3, req_tdata);
                     load_pos   = LOAD_NONE;
                     centre_col = req_tdata[7:0];
                     finished   = 1'b1;
                  end
               end
            endcase
            if (finished) begin
               if (row < int'(LAST_ROW)) begin
                  row_now = 2'(row + 1);
               end else begin
                  row_now = '0;
                  case (int'(centre_col) % 3)
                     0:       centre = int'(CENTRE_MID);
                     1:       centre = int'(CENTRE_RIGHT);
                     default: centre = int'(CENTRE_LEFT);
                  endcase
                  want.red   = filter_value(red_win, centre);
                  want.green = filter_value(green_win, centre);
                  want.blue  = filter_value(blue_win, centre);
                  filtered_q.push_back(want);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_pixel_type'(rsp_tdata);
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
               error_total <= error_total + 1;
            end else begin
               want = filtered_q.pop_front();
               bad = 0;
               if (got.red !== want.red) begin
                  $display("%0t: red mismatch, expected %0d, got %0d", $time, want.red, got.red);
                  bad++;
               end
               if (got.green !== want.green) begin
                  $display("%0t: green mismatch, expected %0d, got %0d", $time, want.green,
                           got.green);
                  bad++;
               end
               if (got.blue !== want.blue) begin
                  $display("%0t: blue mismatch, expected %0d, got %0d", $time, want.blue,
                           got.blue);
                  bad++;
               end
               error_total <= error_total + bad;
            end
         end
      end
      waiting_results <= filtered_q.size();
   end

endmodule

FILE: tb/rgb_median_mean_3x3_filter_tb.sv
`timescale 1ns / 1ps
// testbench top for the rgb median/mean filter: request stimulus, result stalls and verdict
module rgb_median_mean_3x3_filter_tb;

   // cycles with no accepted request or result before the run is declared hung
   localparam int IDLE_LIMIT = 2000;
   localparam int PIXEL_TARGET = 700;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // column, red_in, green_in, blue_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red_out, green_out, blue_out

   int error_total;
   int waiting_results;
   int idle_cycles = 0;
   int pixels_sent = 0;
   int rows_sent   = 0;

   // squeeze: the result side holds off for a long stretch while requests keep coming
   bit squeeze = 1'b0;
   // calm: a stretch where the request side never idles
   bit calm    = 1'b0;

   rgb_median_mean_3x3_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgbmf_filter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_total     (error_total),
      .waiting_results (waiting_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // idle gap before a request: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (squeeze || calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // sample value with the extremes weighted up
   function automatic logic [7:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one request and hold it until the block takes it
   task automatic send_pixel(input logic [7:0] column, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red, column};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic send_random_pixel(input logic [7:0] column);
      send_pixel(column, pick_sample(), pick_sample(), pick_sample());
   endtask

   // column zero starts a full load; the two words after it carry any column
   task automatic send_full_row();
      send_random_pixel(8'd0);
      send_random_pixel(8'($urandom_range(0, 255)));
      send_random_pixel(8'($urandom_range(0, 255)));
      rows_sent++;
   endtask

   // a lone word writes one slot and closes its row at once
   task automatic send_single_row();
      send_random_pixel(8'($urandom_range(1, 255)));
      rows_sent++;
   endtask

   // result side: random stalls of mixed length, long ready runs, and the squeeze
   initial begin : result_side
      int r;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            squeeze = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               rsp_tready <= 1'b1;
               repeat (100) @(posedge clock);
            end else if (r < 60) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else if (r < 92) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end
         end
      end
   end

   // watchdog: any accepted request or result restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all-white window by full loads; the second and third words carry a
      // nonzero column that must be ignored, result saturates at 255
      for (k = 0; k < 3; k++) begin
         send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
         send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
         send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end
      // lone words punch black into a white window; last column picks the left centre
      send_pixel(8'd1, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
      send_pixel(8'd2, 8'h00, 8'h00, 8'h00);
      // lone words again, last column picks the right centre
      send_random_pixel(8'd3);
      send_random_pixel(8'd128);
      send_random_pixel(8'd1);
      // lone words, last column a multiple of three: middle centre
      send_random_pixel(8'd4);
      send_random_pixel(8'h55);
      send_random_pixel(8'd6);
      // a lone word between full loads; the final full load resets the centre column
      send_full_row();
      send_pixel(8'd2, pick_sample(), pick_sample(), pick_sample());
      send_full_row();

      // random part, opening with a long result stall so the pipeline backs up
      squeeze = 1'b1;
      while (pixels_sent < PIXEL_TARGET) begin
         calm = ((rows_sent / 20) % 5) == 4;
         if (pixels_sent > PIXEL_TARGET / 2 && pixels_sent < PIXEL_TARGET / 2 + 4)
            squeeze = 1'b1;
         if ($urandom_range(0, 99) < 70)
            send_full_row();
         else
            send_single_row();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // let the checker count the last request, then drain every outstanding
      // result and leave room for anything stray
      @(posedge clock);
      while (waiting_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_total == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/rgbmf_pkg.sv
rtl/rgbmf_window.sv
rtl/rgbmf_lane.sv
rtl/rgb_median_mean_3x3_filter.sv
tb/rgbmf_filter_checker.sv
tb/rgb_median_mean_3x3_filter_tb.sv
